[hdl/txt2int_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txt2int_pkg
// Shared widths, character codes, phase type and digit helpers for the
// streaming text-to-integer parser.
// ----------------------------------------------------------------------------
package txt2int_pkg;

    // Datapath sizing
    localparam int VALUE_WIDTH    = 32;
    localparam int POSITION_WIDTH = 16;
    localparam int BASE_WIDTH     = 6;
    localparam int CHAR_WIDTH     = 8;
    localparam int DIGIT_WIDTH    = 8;
    localparam int PROD_WIDTH     = VALUE_WIDTH + BASE_WIDTH + 1;

    // Result field layout
    localparam int VALUE_FIELD_WIDTH = 32;
    localparam int END_FIELD_WIDTH   = 16;
    localparam int OUT_TDATA_WIDTH   = 56;
    localparam int OUT_PAD_WIDTH     = OUT_TDATA_WIDTH - VALUE_FIELD_WIDTH
                                       - END_FIELD_WIDTH - 2;

    // Configuration port
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;
    localparam logic REG_NUMBER_BASE = 1'b0;

    localparam logic [PROD_WIDTH-1:0] HALF_RANGE = PROD_WIDTH'(1) << (VALUE_WIDTH - 1);
    localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

    // Character codes
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_Z = 8'h5a;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_Z = 8'h7a;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS   = 8'h2d;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS    = 8'h2b;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_CR      = 8'h0d;
    localparam logic [CHAR_WIDTH-1:0] UPPER_BIAS = 8'h37;  // 'A' - 10
    localparam logic [CHAR_WIDTH-1:0] LOWER_BIAS = 8'h57;  // 'a' - 10

    localparam logic [DIGIT_WIDTH-1:0] NOT_DIGIT = 8'hff;

    // Radix codes
    localparam logic [BASE_WIDTH-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_WIDTH-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_WIDTH-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_WIDTH-1:0] BASE_HEX  = 6'd16;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_HEX,
        PH_DIGITS
    } phase_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] acc;
        logic                   overflow;
    } mac_res_t;

    function automatic logic [DIGIT_WIDTH-1:0] digit_of(input logic [CHAR_WIDTH-1:0] c);
        logic [DIGIT_WIDTH-1:0] d;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            d = c - CH_ZERO;
        end else if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            d = c - UPPER_BIAS;
        end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            d = c - LOWER_BIAS;
        end else begin
            d = NOT_DIGIT;
        end
        return d;
    endfunction

    function automatic logic is_space(input logic [CHAR_WIDTH-1:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

endpackage
`default_nettype wire

[hdl/txt2int_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txt2int_mac
// Multiply-accumulate of one digit with a saturation check against the
// signed limit for the current sign.
// ----------------------------------------------------------------------------
module txt2int_mac (
    input  wire logic [txt2int_pkg::VALUE_WIDTH-1:0] acc_i,
    input  wire logic [txt2int_pkg::BASE_WIDTH-1:0]  base_i,
    input  wire logic [txt2int_pkg::DIGIT_WIDTH-1:0] digit_i,
    input  wire logic                                negative_i,
    output txt2int_pkg::mac_res_t                    res_o
);

    logic [txt2int_pkg::PROD_WIDTH-1:0] prod;
    logic [txt2int_pkg::PROD_WIDTH-1:0] limit;

    assign prod = txt2int_pkg::PROD_WIDTH'(acc_i) * txt2int_pkg::PROD_WIDTH'(base_i)
                + txt2int_pkg::PROD_WIDTH'(digit_i);

    // Magnitude may reach the half range only for a negative value
    assign limit = negative_i ? txt2int_pkg::HALF_RANGE
                              : txt2int_pkg::HALF_RANGE - txt2int_pkg::PROD_WIDTH'(1);

    assign res_o.overflow = (prod > limit);
    assign res_o.acc      = prod[txt2int_pkg::VALUE_WIDTH-1:0];

endmodule
`default_nettype wire

[hdl/text_to_integer_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_to_integer_parser
// Streaming strtol-style converter: one character per transfer in, one
// result transfer per terminated number out.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_*       in         tdata[7:0] char_code, tuser start_flag
//  m_*       out        tdata: [31:0] value, [47:32] end_offset,
//                       [48] overflowed, [49] had_digits
//  APB       in/out     0x0 number_base[5:0]
//
//  Each character passes through the parse stage; a new character can be
//  taken every cycle unless a stalled result holds the parse stage. An
//  input transfer goes through the input register, then the parse step
//  (one 32x6 multiply, add and limit compare) into the result register.
//  Reset (aresetn low, synchronous) empties both stages, clears the base
//  register and leaves the parser idle until a character with start_flag.
//  A stalled result holds the parse stage; the input register still takes
//  one character while it is empty.
//
module text_to_integer_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Character stream
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tuser,   // [0] start_flag

    // Result stream
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [55:0] m_tdata,   // [31:0] value, [47:32] end_offset,
                                        // [48] overflowed, [49] had_digits

    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    localparam int VW = txt2int_pkg::VALUE_WIDTH;
    localparam int PW = txt2int_pkg::POSITION_WIDTH;
    localparam int BW = txt2int_pkg::BASE_WIDTH;
    localparam int CW = txt2int_pkg::CHAR_WIDTH;
    localparam int DW = txt2int_pkg::DIGIT_WIDTH;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [BW-1:0] number_base_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            number_base_reg <= txt2int_pkg::BASE_AUTO;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == txt2int_pkg::REG_NUMBER_BASE)) begin
            number_base_reg <= pwdata[BW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == txt2int_pkg::REG_NUMBER_BASE) begin
            prdata = txt2int_pkg::APB_DATA_WIDTH'(number_base_reg);
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic          in_valid_reg;
    logic [CW-1:0] in_char_reg;
    logic          in_start_reg;
    logic          out_valid_reg;
    logic          proc_go;

    // Parse the held character whenever the result slot is free or draining
    assign proc_go  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    txt2int_pkg::phase_t phase_reg, phase_next;
    logic          negative_reg, negative_next;
    logic [VW-1:0] acc_reg, acc_next;
    logic [BW-1:0] eff_base_reg, eff_base_next;
    logic          seen_reg, seen_next;
    logic          ovf_reg, ovf_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic          fin_reg, fin_next;

    // State as seen by this character: a start wipes the previous string
    txt2int_pkg::phase_t cur_phase;
    logic          cur_neg;
    logic [VW-1:0] cur_acc;
    logic [BW-1:0] cur_eb;
    logic          cur_seen;
    logic          cur_ovf;
    logic [PW-1:0] cur_pos;
    logic          cur_fin;

    assign cur_phase = in_start_reg ? txt2int_pkg::PH_SPACE : phase_reg;
    assign cur_neg   = in_start_reg ? 1'b0 : negative_reg;
    assign cur_acc   = in_start_reg ? '0 : acc_reg;
    assign cur_eb    = in_start_reg ? txt2int_pkg::BASE_AUTO : eff_base_reg;
    assign cur_seen  = in_start_reg ? 1'b0 : seen_reg;
    assign cur_ovf   = in_start_reg ? 1'b0 : ovf_reg;
    assign cur_pos   = in_start_reg ? '0 : pos_reg;
    assign cur_fin   = in_start_reg ? 1'b0 : fin_reg;

    logic [DW-1:0] digit;
    logic          is_x;
    logic          is_zero;
    logic          first_char;
    logic          try_digit;
    logic          take;
    logic          emit;
    logic [DW-1:0] mac_digit;
    logic [PW-1:0] emit_end;
    txt2int_pkg::mac_res_t mac_res;

    assign digit   = txt2int_pkg::digit_of(in_char_reg);
    assign is_x    = (in_char_reg == txt2int_pkg::CH_LOWER_X)
                  || (in_char_reg == txt2int_pkg::CH_UPPER_X);
    assign is_zero = (in_char_reg == txt2int_pkg::CH_ZERO);

    // Phase decode: choose radix, decide whether a digit is taken or the
    // number ends here
    always_comb begin
        phase_next    = cur_phase;
        negative_next = cur_neg;
        eff_base_next = cur_eb;
        fin_next      = cur_fin;
        first_char    = 1'b0;
        try_digit     = 1'b0;
        take          = 1'b0;
        emit          = 1'b0;
        mac_digit     = digit;
        emit_end      = cur_pos;

        if (!cur_fin) begin
            case (cur_phase)
                txt2int_pkg::PH_SPACE: begin
                    if (txt2int_pkg::is_space(in_char_reg)) begin
                        phase_next = txt2int_pkg::PH_SPACE;
                    end else if (in_char_reg == txt2int_pkg::CH_MINUS) begin
                        negative_next = 1'b1;
                        phase_next    = txt2int_pkg::PH_SIGNED;
                    end else if (in_char_reg == txt2int_pkg::CH_PLUS) begin
                        phase_next = txt2int_pkg::PH_SIGNED;
                    end else begin
                        first_char = 1'b1;
                    end
                end
                txt2int_pkg::PH_SIGNED: begin
                    first_char = 1'b1;
                end
                txt2int_pkg::PH_ZERO: begin
                    if (is_x) begin
                        eff_base_next = txt2int_pkg::BASE_HEX;
                        phase_next    = txt2int_pkg::PH_HEX;
                    end else begin
                        try_digit = 1'b1;
                    end
                end
                txt2int_pkg::PH_HEX: begin
                    if (digit < DW'(txt2int_pkg::BASE_HEX)) begin
                        try_digit = 1'b1;
                    end else begin
                        // Bare prefix: the number is the leading zero, ending at the x
                        emit     = 1'b1;
                        emit_end = (cur_pos == txt2int_pkg::POS_MAX) ? cur_pos
                                                                     : cur_pos - PW'(1);
                    end
                end
                default: begin
                    try_digit = 1'b1;
                end
            endcase

            if (first_char) begin
                if (is_zero && ((number_base_reg == txt2int_pkg::BASE_AUTO)
                                || (number_base_reg == txt2int_pkg::BASE_HEX))) begin
                    eff_base_next = (number_base_reg == txt2int_pkg::BASE_AUTO)
                                    ? txt2int_pkg::BASE_OCT : txt2int_pkg::BASE_HEX;
                    take       = 1'b1;
                    mac_digit  = '0;
                    phase_next = txt2int_pkg::PH_ZERO;
                end else begin
                    eff_base_next = (number_base_reg == txt2int_pkg::BASE_AUTO)
                                    ? txt2int_pkg::BASE_DEC : number_base_reg;
                    try_digit = 1'b1;
                end
            end

            if (try_digit) begin
                if (digit < DW'(eff_base_next)) begin
                    take       = 1'b1;
                    phase_next = txt2int_pkg::PH_DIGITS;
                end else begin
                    emit     = 1'b1;
                    emit_end = cur_pos;
                end
            end

            if (emit) begin
                fin_next = 1'b1;
            end
        end
    end

    txt2int_mac u_mac (
        .acc_i      (cur_acc),
        .base_i     (eff_base_next),
        .digit_i    (mac_digit),
        .negative_i (negative_next),
        .res_o      (mac_res)
    );

    // Apply the digit; once saturated, later digits only count as seen
    always_comb begin
        acc_next  = cur_acc;
        seen_next = cur_seen;
        ovf_next  = cur_ovf;
        pos_next  = cur_pos;
        if (take) begin
            seen_next = 1'b1;
            if (!cur_ovf) begin
                if (mac_res.overflow) begin
                    ovf_next = 1'b1;
                end else begin
                    acc_next = mac_res.acc;
                end
            end
        end
        if (!cur_fin && (cur_pos != txt2int_pkg::POS_MAX)) begin
            pos_next = cur_pos + PW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= txt2int_pkg::PH_SPACE;
            negative_reg <= 1'b0;
            acc_reg      <= '0;
            eff_base_reg <= txt2int_pkg::BASE_AUTO;
            seen_reg     <= 1'b0;
            ovf_reg      <= 1'b0;
            pos_reg      <= '0;
            fin_reg      <= 1'b1;
        end else if (proc_go) begin
            phase_reg    <= phase_next;
            negative_reg <= negative_next;
            acc_reg      <= acc_next;
            eff_base_reg <= eff_base_next;
            seen_reg     <= seen_next;
            ovf_reg      <= ovf_next;
            pos_reg      <= pos_next;
            fin_reg      <= fin_next;
        end
    end

    // ------------------------------------------------------------------
    // Result formatting and output register
    // ------------------------------------------------------------------
    logic [VW-1:0] val_full;
    logic [txt2int_pkg::VALUE_FIELD_WIDTH-1:0] val_field;
    logic [txt2int_pkg::END_FIELD_WIDTH-1:0]   end_field;
    logic [txt2int_pkg::OUT_TDATA_WIDTH-1:0]   out_data_reg;

    always_comb begin
        if (!cur_seen) begin
            val_full = '0;
        end else if (cur_ovf) begin
            val_full = cur_neg ? txt2int_pkg::HALF_RANGE[VW-1:0]
                               : txt2int_pkg::HALF_RANGE[VW-1:0] - VW'(1);
        end else begin
            val_full = cur_neg ? (VW'(0) - cur_acc) : cur_acc;
        end
    end

    // Sign-extend or truncate the value to the field width
    assign val_field = txt2int_pkg::VALUE_FIELD_WIDTH'(64'(signed'(val_full)));
    assign end_field = cur_seen ? txt2int_pkg::END_FIELD_WIDTH'(emit_end) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_go) begin
            out_valid_reg <= emit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_go && emit) begin
            out_data_reg <= {{txt2int_pkg::OUT_PAD_WIDTH{1'b0}},
                             cur_seen,
                             cur_seen && cur_ovf,
                             end_field,
                             val_field};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming text-to-integer parser. Characters
// go in as stream transfers while a scoreboard tracks the parse state and
// predicts each number; every result transfer is compared field by field.
// Directed strings cover limits, prefixes and base sampling, then random
// strings run under a range of base settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT     = 3_000_000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 18;

    localparam logic [txt2int_pkg::BASE_WIDTH-1:0] UNARY_BASE  = 6'd1;
    localparam logic [txt2int_pkg::BASE_WIDTH-1:0] BINARY_BASE = 6'd2;
    localparam logic [txt2int_pkg::BASE_WIDTH-1:0] MAX_BASE    = 6'd36;
    localparam logic [txt2int_pkg::BASE_WIDTH-1:0] WIDEST_BASE = 6'd63;

    localparam logic [txt2int_pkg::APB_ADDR_WIDTH-1:0] BASE_ADDR =
        txt2int_pkg::APB_ADDR_WIDTH'(txt2int_pkg::REG_NUMBER_BASE) << 2;

    typedef struct packed {
        logic       st;
        logic [7:0] c;
    } char_item_t;

    typedef struct {
        logic signed [31:0] value;
        logic [15:0]        end_offset;
        logic               overflowed;
        logic               had_digits;
    } parsed_number_t;

    typedef enum int {
        RX_STEADY,
        RX_RANDOM,
        RX_TOGGLE,
        RX_CHOKED
    } rx_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow parser state plus the numbers it still expects
    // ------------------------------------------------------------------------
    class number_scoreboard;
        logic [txt2int_pkg::BASE_WIDTH-1:0] base_reg = txt2int_pkg::BASE_AUTO;
        txt2int_pkg::phase_t                phase = txt2int_pkg::PH_SPACE;
        bit                                 negative = 1'b0;
        logic [63:0]                        magnitude = '0;
        logic [txt2int_pkg::BASE_WIDTH-1:0] radix = '0;
        bit                                 digit_seen = 1'b0;
        bit                                 ovf_seen = 1'b0;
        logic [15:0]                        pos = '0;
        bit                                 finished = 1'b1;
        parsed_number_t                     expected_numbers[$];
        int                                 errors = 0;
        int                                 results_seen = 0;

        function int unsigned char_digit(logic [7:0] c);
            if (c >= txt2int_pkg::CH_ZERO && c <= txt2int_pkg::CH_NINE)
                return c - txt2int_pkg::CH_ZERO;
            if (c >= txt2int_pkg::CH_UPPER_A && c <= txt2int_pkg::CH_UPPER_Z)
                return c - txt2int_pkg::UPPER_BIAS;
            if (c >= txt2int_pkg::CH_LOWER_A && c <= txt2int_pkg::CH_LOWER_Z)
                return c - txt2int_pkg::LOWER_BIAS;
            return txt2int_pkg::NOT_DIGIT;
        endfunction

        function bit is_blank(logic [7:0] c);
            return (c == txt2int_pkg::CH_SPACE)
                || (c >= txt2int_pkg::CH_TAB && c <= txt2int_pkg::CH_CR);
        endfunction

        // Saturate once the next step would pass the signed limit
        function void accept_digit(int unsigned d);
            logic [63:0] lim;
            lim = negative ? 64'h8000_0000 : 64'h7fff_ffff;
            digit_seen = 1'b1;
            if (ovf_seen) return;
            if (magnitude > (lim - d) / radix) begin
                ovf_seen = 1'b1;
            end else begin
                magnitude = magnitude * radix + d;
            end
        endfunction

        function void finish_number(logic [15:0] end_pos);
            parsed_number_t r;
            if (!digit_seen) begin
                r.value      = '0;
                r.end_offset = '0;
            end else begin
                if (ovf_seen) begin
                    r.value = negative ? 32'h8000_0000 : 32'h7fff_ffff;
                end else begin
                    r.value = 32'(negative ? (64'd0 - magnitude) : magnitude);
                end
                r.end_offset = end_pos;
            end
            r.overflowed = digit_seen && ovf_seen;
            r.had_digits = digit_seen;
            expected_numbers.push_back(r);
            finished = 1'b1;
        endfunction

        function void digit_or_finish(logic [7:0] c);
            int unsigned d;
            d = char_digit(c);
            if (d < radix) begin
                accept_digit(d);
                phase = txt2int_pkg::PH_DIGITS;
            end else begin
                finish_number(pos);
            end
        endfunction

        // The base register is sampled here, on the first character after
        // whitespace and sign
        function void first_digit(logic [7:0] c);
            if (c == txt2int_pkg::CH_ZERO && (base_reg == txt2int_pkg::BASE_AUTO
                                              || base_reg == txt2int_pkg::BASE_HEX)) begin
                radix = (base_reg == txt2int_pkg::BASE_AUTO) ? txt2int_pkg::BASE_OCT
                                                             : txt2int_pkg::BASE_HEX;
                accept_digit(0);
                phase = txt2int_pkg::PH_ZERO;
            end else begin
                radix = (base_reg == txt2int_pkg::BASE_AUTO) ? txt2int_pkg::BASE_DEC
                                                             : base_reg;
                digit_or_finish(c);
            end
        endfunction

        function void note_char(logic [7:0] c, logic st);
            if (st) begin
                phase      = txt2int_pkg::PH_SPACE;
                negative   = 1'b0;
                magnitude  = '0;
                radix      = '0;
                digit_seen = 1'b0;
                ovf_seen   = 1'b0;
                pos        = '0;
                finished   = 1'b0;
            end
            if (finished) return;
            case (phase)
                txt2int_pkg::PH_SPACE: begin
                    if (is_blank(c)) begin
                    end else if (c == txt2int_pkg::CH_MINUS) begin
                        negative = 1'b1;
                        phase    = txt2int_pkg::PH_SIGNED;
                    end else if (c == txt2int_pkg::CH_PLUS) begin
                        phase = txt2int_pkg::PH_SIGNED;
                    end else begin
                        first_digit(c);
                    end
                end
                txt2int_pkg::PH_SIGNED: first_digit(c);
                txt2int_pkg::PH_ZERO: begin
                    if (c == txt2int_pkg::CH_LOWER_X || c == txt2int_pkg::CH_UPPER_X) begin
                        radix = txt2int_pkg::BASE_HEX;
                        phase = txt2int_pkg::PH_HEX;
                    end else begin
                        digit_or_finish(c);
                    end
                end
                txt2int_pkg::PH_HEX: begin
                    // A bare prefix ends at the 'x' unless the offset saturated
                    if (char_digit(c) < 16) begin
                        digit_or_finish(c);
                    end else begin
                        finish_number((pos == txt2int_pkg::POS_MAX) ? pos : pos - 16'd1);
                    end
                end
                default: digit_or_finish(c);
            endcase
            if (pos != txt2int_pkg::POS_MAX) pos++;
        endfunction

        function void check_result(logic [55:0] t);
            parsed_number_t want;
            results_seen++;
            if (expected_numbers.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual value %0d offset %0d",
                         $time, $signed(t[31:0]), t[47:32]);
                return;
            end
            want = expected_numbers.pop_front();
            if (t[31:0] !== want.value) begin
                errors++;
                $display("%0t: value mismatch, expected %0d, actual %0d",
                         $time, want.value, $signed(t[31:0]));
            end
            if (t[47:32] !== want.end_offset) begin
                errors++;
                $display("%0t: end_offset mismatch, expected %0d, actual %0d",
                         $time, want.end_offset, t[47:32]);
            end
            if (t[48] !== want.overflowed) begin
                errors++;
                $display("%0t: overflowed mismatch, expected %0b, actual %0b",
                         $time, want.overflowed, t[48]);
            end
            if (t[49] !== want.had_digits) begin
                errors++;
                $display("%0t: had_digits mismatch, expected %0b, actual %0b",
                         $time, want.had_digits, t[49]);
            end
            if (t[55:50] !== '0) begin
                errors++;
                $display("%0t: tdata padding mismatch, expected 0, actual %0h",
                         $time, t[55:50]);
            end
        endfunction

        function int pending();
            return expected_numbers.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block under test
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;     // [7:0] char_code
    logic        s_tuser  = 1'b0;   // [0] start_flag
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;           // [31:0] value, [47:32] end_offset,
                                    // [48] overflowed, [49] had_digits
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    always #4 aclk = ~aclk;

    text_to_integer_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    number_scoreboard sb = new;
    char_item_t       stim_q[$];
    int               chars_sent  = 0;
    int               base_writes = 0;
    int               cycles      = 0;
    rx_mode_t         rx_mode     = RX_STEADY;
    int               rx_left     = 0;

    // ------------------------------------------------------------------------
    // Result side: stall on a randomly chosen pattern that is redrawn when its run ends,
    // and check every transfer against the oldest expected number
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_STEADY: m_tready <= 1'b1;
            RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
            RX_TOGGLE: m_tready <= ~m_tready;
            default:   m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Hang guard: far above the slowest legal run
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d numbers outstanding",
                     cycles, sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] c, input logic st);
        stim_q.push_back({st, c});
    endtask

    task automatic queue_text(input string s, input logic st);
        for (int i = 0; i < s.len(); i++) stim_q.push_back({1'(st && (i == 0)), s[i]});
    endtask

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? txt2int_pkg::CH_SPACE : txt2int_pkg::CH_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] end_char();
        case ($urandom_range(0, 7))
            0: return ".";
            1: return ",";
            2: return ";";
            3: return txt2int_pkg::CH_SPACE;
            4: return 8'h00;
            5: return 8'hff;
            6: return "_";
            default: return "~";
        endcase
    endfunction

    function automatic logic [7:0] digit_char(input int unsigned d);
        if (d < 10) return txt2int_pkg::CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? txt2int_pkg::CH_LOWER_A : txt2int_pkg::CH_UPPER_A)
               + 8'(d - 10);
    endfunction

    // Build one string: mostly well-formed numbers with random content,
    // some noise, unterminated strings and characters without a start
    task automatic make_string(input logic [txt2int_pkg::BASE_WIDTH-1:0] b,
                               inout int counted);
        logic [7:0] txt[$];
        string      near = "214748364";
        int         kind;
        int         n;
        int         db;
        bit         with_start;
        kind = $urandom_range(0, 19);
        with_start = (kind != 1);
        if (kind <= 1) begin
            n = $urandom_range(1, 8);
            repeat (n) txt.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3)) txt.push_back(blank_char());
            end
            case ($urandom_range(0, 3))
                0: txt.push_back(txt2int_pkg::CH_MINUS);
                1: txt.push_back(txt2int_pkg::CH_PLUS);
                default: ;
            endcase
            db = (b > MAX_BASE) ? MAX_BASE : b;
            if (b == txt2int_pkg::BASE_AUTO) db = txt2int_pkg::BASE_DEC;
            if ((b == txt2int_pkg::BASE_AUTO || b == txt2int_pkg::BASE_HEX)
                && $urandom_range(0, 2) == 0) begin
                txt.push_back(txt2int_pkg::CH_ZERO);
                txt.push_back($urandom_range(0, 1) ? txt2int_pkg::CH_LOWER_X
                                                   : txt2int_pkg::CH_UPPER_X);
                db = txt2int_pkg::BASE_HEX;
            end else if (b == txt2int_pkg::BASE_AUTO && $urandom_range(0, 3) == 0) begin
                txt.push_back(txt2int_pkg::CH_ZERO);
                db = txt2int_pkg::BASE_OCT;
            end
            if (kind == 2 && db == txt2int_pkg::BASE_DEC) begin
                // Straddle the signed limit
                for (int i = 0; i < near.len(); i++) txt.push_back(near[i]);
                txt.push_back(txt2int_pkg::CH_ZERO + 8'($urandom_range(6, 9)));
            end else begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                if ($urandom_range(0, 15) == 0) n = 0;
                repeat (n) txt.push_back(digit_char($urandom_range(0, db - 1)));
            end
            // Drop the terminator now and then; the next start discards it
            if (kind != 3) begin
                txt.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : end_char());
            end
        end
        for (int i = 0; i < txt.size(); i++) stim_q.push_back({1'(with_start && i == 0), txt[i]});
        counted += txt.size();
        // Trailing bytes after a result are ignored and not counted
        if (kind > 3 && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) stim_q.push_back({1'b0, 8'($urandom_range(0, 255))});
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender: transfer the queued characters in bursts with random gaps
    // ------------------------------------------------------------------------
    task automatic run_queue();
        char_item_t it;
        int         burst_left;
        int         gap;
        burst_left = 0;
        while (stim_q.size() > 0) begin
            it = stim_q.pop_front();
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 20);
            end
            burst_left--;
            s_tvalid <= 1'b1;
            s_tdata  <= it.c;
            s_tuser  <= it.st;
            do @(posedge aclk); while (!s_tready);
            sb.note_char(it.c, it.st);
            chars_sent++;
        end
        s_tvalid <= 1'b0;
    endtask

    // Wait out every expected number, then let the pipe empty of characters
    // that cause no result
    task automatic settle();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the base register, then read it back
    task automatic write_base(input logic [txt2int_pkg::BASE_WIDTH-1:0] b);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BASE_ADDR;
        pwdata  <= 32'(b);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.base_reg = b;
        base_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== 32'(b)) begin
            sb.errors++;
            $display("%0t: number_base readback mismatch, expected %0d, actual %0d",
                     $time, b, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [txt2int_pkg::BASE_WIDTH-1:0] b;
        int                                 counted;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Base 0 after reset; characters before any start are ignored
        queue_text("12;", 1'b0);
        queue_text(" -2147483648;", 1'b1);
        queue_text("+2147483647 ", 1'b1);
        queue_text("2147483648,", 1'b1);
        queue_text("-2147483649;", 1'b1);
        queue_text("0x7fffffffZ", 1'b1);
        queue_text("-0X80000000.", 1'b1);
        queue_text("0xg", 1'b1);
        queue_text("017.", 1'b1);
        queue_text("09", 1'b1);
        queue_byte(txt2int_pkg::CH_TAB, 1'b1);
        queue_byte(8'h0a, 1'b0);
        queue_byte(8'h0b, 1'b0);
        queue_byte(8'h0c, 1'b0);
        queue_byte(txt2int_pkg::CH_CR, 1'b0);
        queue_text(" 42!", 1'b0);
        queue_text("-x", 1'b1);
        queue_byte(8'hff, 1'b1);
        queue_text("+-5", 1'b1);
        // Restart in the middle of a number
        queue_text(" 12", 1'b1);
        queue_text("7;", 1'b1);
        // Characters after a result are ignored until the next start
        queue_text("5;", 1'b1);
        queue_text("99;", 1'b0);
        queue_text("0", 1'b1);
        queue_byte(8'h80, 1'b0);
        run_queue();
        settle();

        write_base(UNARY_BASE);
        queue_text("0001;", 1'b1);
        queue_text("-00x", 1'b1);
        queue_text("1", 1'b1);
        run_queue();
        settle();

        write_base(MAX_BASE);
        queue_text("zZ;", 1'b1);
        queue_text("zzzzzzz!", 1'b1);
        queue_text("-0x1.", 1'b1);
        run_queue();
        settle();

        write_base(WIDEST_BASE);
        queue_text("zz!", 1'b1);
        queue_text("-ZZZZZZ~", 1'b1);
        run_queue();
        settle();

        write_base(txt2int_pkg::BASE_HEX);
        queue_text("0xFF.", 1'b1);
        queue_text("0x;", 1'b1);
        queue_text("ff_", 1'b1);
        queue_text("-0x80000001;", 1'b1);
        run_queue();
        settle();

        write_base(BINARY_BASE);
        queue_text("1011 2", 1'b1);
        queue_text("-1111111111111111111111111111111111;", 1'b1);
        run_queue();
        settle();

        // Base is sampled on the first digit: a write after the sign counts,
        // a write after the first digit does not
        write_base(txt2int_pkg::BASE_DEC);
        queue_text("-", 1'b1);
        run_queue();
        settle();
        write_base(MAX_BASE);
        queue_text("z;", 1'b0);
        queue_text("12", 1'b1);
        run_queue();
        settle();
        write_base(txt2int_pkg::BASE_DEC);
        queue_text("a;", 1'b0);
        run_queue();
        settle();

        // Random strings under a spread of base settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: b = txt2int_pkg::BASE_AUTO;
                1: b = UNARY_BASE;
                2: b = BINARY_BASE;
                3: b = txt2int_pkg::BASE_OCT;
                4: b = txt2int_pkg::BASE_DEC;
                5: b = txt2int_pkg::BASE_HEX;
                6: b = MAX_BASE;
                7: b = WIDEST_BASE;
                8: b = txt2int_pkg::BASE_WIDTH'($urandom_range(0, MAX_BASE));
                default: b = txt2int_pkg::BASE_AUTO;
            endcase
            write_base(b);
            counted = 0;
            while (counted < ITEMS_PER_PHASE) make_string(b, counted);
            run_queue();
            settle();
        end

        $display("Sent %0d characters under %0d base settings; checked %0d numbers",
                 chars_sent, base_writes, sb.results_seen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
